// ===== src/dbd_pkg.sv =====
// Shared types, widths and calendar tables for the day-count pipeline.
// No dependencies; imported by dbd_date_serial and days_between_dates.
package dbd_pkg;

    // Field widths
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int COUNT_W = 23;
    localparam int QUOT_W  = 8;
    localparam int MLEN_W  = 5;
    localparam int DOY_W   = 9;

    // Stream packing
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 24;

    // Calendar constants
    localparam int unsigned YEAR_MAX     = 9999;
    localparam int unsigned DAYS_IN_YEAR = 365;
    localparam int unsigned CENTURY      = 100;
    localparam int unsigned QUAD_BIAS    = 3;
    localparam int unsigned CENT_BIAS    = 99;
    localparam int unsigned QCENT_BIAS   = 399;
    localparam int unsigned FEB_LEAP_LEN = 29;

    // Divide by 100 as multiply by reciprocal; exact for inputs below 43690
    localparam int unsigned DIV100_MUL   = 5243;
    localparam int          DIV100_SHIFT = 19;
    localparam int          PROD_W       = 28;

    localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

    // Load enables for the three stages of a date unit
    typedef struct packed {
        logic stage_a;
        logic stage_b;
        logic stage_c;
    } stage_en_t;

    // Quotient by 100 of a value of up to YEAR_W+1 bits, kept to its low QUOT_W bits
    function automatic logic [QUOT_W-1:0] div100(input logic [YEAR_W:0] x);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(x) * PROD_W'(DIV100_MUL);
        return prod[DIV100_SHIFT +: QUOT_W];
    endfunction

    // Days in the months before the given one, common year
    function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
        logic [DOY_W-1:0] r;
        case (m)
            4'd1:    r = DOY_W'(0);
            4'd2:    r = DOY_W'(31);
            4'd3:    r = DOY_W'(59);
            4'd4:    r = DOY_W'(90);
            4'd5:    r = DOY_W'(120);
            4'd6:    r = DOY_W'(151);
            4'd7:    r = DOY_W'(181);
            4'd8:    r = DOY_W'(212);
            4'd9:    r = DOY_W'(243);
            4'd10:   r = DOY_W'(273);
            4'd11:   r = DOY_W'(304);
            4'd12:   r = DOY_W'(334);
            default: r = DOY_W'(0);
        endcase
        return r;
    endfunction

    // Month length, common year
    function automatic logic [MLEN_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [MLEN_W-1:0] r;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = MLEN_W'(31);
            4'd4, 4'd6, 4'd9, 4'd11:                    r = MLEN_W'(30);
            4'd2:                                       r = MLEN_W'(28);
            default:                                    r = MLEN_W'(0);
        endcase
        return r;
    endfunction

endpackage

// ===== src/dbd_date_serial.sv =====
// Three-stage unit turning one date into its serial day number and a valid flag.
// Depends on dbd_pkg; stage loads come from the pipeline control in the top level.
module dbd_date_serial (
    input  logic                          aclk,
    input  dbd_pkg::stage_en_t            en,
    input  logic [dbd_pkg::YEAR_W-1:0]    year,
    input  logic [dbd_pkg::MONTH_W-1:0]   month,
    input  logic [dbd_pkg::DAY_W-1:0]     day,
    output logic [dbd_pkg::COUNT_W-1:0]   serial,
    output logic                          date_ok
);
    import dbd_pkg::*;

    // Stage A: century quotients by reciprocal multiply
    logic [YEAR_W:0]    y99, y399;
    logic [YEAR_W-1:0]  year_a_reg;
    logic [MONTH_W-1:0] month_a_reg;
    logic [DAY_W-1:0]   day_a_reg;
    logic [QUOT_W-1:0]  qy_a_reg, q99_a_reg, q399_a_reg;

    assign y99  = {1'b0, year} + (YEAR_W+1)'(CENT_BIAS);
    assign y399 = {1'b0, year} + (YEAR_W+1)'(QCENT_BIAS);

    always_ff @(posedge aclk) begin
        if (en.stage_a) begin
            year_a_reg  <= year;
            month_a_reg <= month;
            day_a_reg   <= day;
            qy_a_reg    <= div100({1'b0, year});
            q99_a_reg   <= div100(y99);
            q399_a_reg  <= div100(y399);
        end
    end

    // Stage B: leap rule, range check and whole-year part of the serial
    logic [YEAR_W-1:0]  cent_b, rem_b;
    logic [YEAR_W:0]    y3_b;
    logic               leap_b, ok_b;
    logic [MLEN_W-1:0]  len_b;
    logic [COUNT_W-1:0] yearpart_b;

    logic [COUNT_W-1:0] yearpart_b_reg;
    logic [MONTH_W-1:0] month_b_reg;
    logic [DAY_W-1:0]   day_b_reg;
    logic               leap_b_reg, ok_b_reg;

    always_comb begin
        cent_b = YEAR_W'(qy_a_reg) * YEAR_W'(CENTURY);
        rem_b  = year_a_reg - cent_b;
        leap_b = (year_a_reg[1:0] == 2'b00) &&
                 ((rem_b != '0) || (qy_a_reg[1:0] == 2'b00));
        len_b  = (month_a_reg == MONTH_FEB && leap_b) ? MLEN_W'(FEB_LEAP_LEN)
                                                       : month_len(month_a_reg);
        ok_b   = (year_a_reg <= YEAR_W'(YEAR_MAX)) &&
                 (month_a_reg >= MONTH_JAN) && (month_a_reg <= MONTH_DEC) &&
                 (day_a_reg != '0) && (MLEN_W'(day_a_reg) <= len_b);
        y3_b   = {1'b0, year_a_reg} + (YEAR_W+1)'(QUAD_BIAS);
        yearpart_b = COUNT_W'(year_a_reg) * COUNT_W'(DAYS_IN_YEAR)
                   + COUNT_W'(y3_b[YEAR_W:2])
                   - COUNT_W'(q99_a_reg)
                   + COUNT_W'(q399_a_reg[QUOT_W-1:2]);
    end

    always_ff @(posedge aclk) begin
        if (en.stage_b) begin
            yearpart_b_reg <= yearpart_b;
            month_b_reg    <= month_a_reg;
            day_b_reg      <= day_a_reg;
            leap_b_reg     <= leap_b;
            ok_b_reg       <= ok_b;
        end
    end

    // Stage C: add day of year
    logic [COUNT_W-1:0] serial_c_next;
    logic [COUNT_W-1:0] serial_c_reg;
    logic               ok_c_reg;

    always_comb begin
        serial_c_next = yearpart_b_reg
                      + COUNT_W'(days_before(month_b_reg))
                      + COUNT_W'((month_b_reg > MONTH_FEB) && leap_b_reg)
                      + COUNT_W'(day_b_reg);
    end

    always_ff @(posedge aclk) begin
        if (en.stage_c) begin
            serial_c_reg <= serial_c_next;
            ok_c_reg     <= ok_b_reg;
        end
    end

    assign serial  = serial_c_reg;
    assign date_ok = ok_c_reg;

endmodule

// ===== src/days_between_dates.sv =====
// Top level: inclusive day count between two Gregorian dates, stream in and out.
// Depends on dbd_pkg and dbd_date_serial.
//
// Takes one pair of dates per beat and returns one beat with the inclusive day
// count (second serial minus first serial plus one, two's complement, negative
// when the second date is more than a day earlier) and an error flag that is set, with a zero
// count, when either month, day or year is out of range. One beat is accepted
// every cycle unless a stall on m_tready has filled the pipeline; beats pass the
// four-stage pipeline (two date units of three stages each, then the difference
// in the output register). Each stage holds its beat only while the stage after
// it is full and stalled, so bubbles close up during a stall and nothing is lost.
module days_between_dates (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // first_year, first_month, first_day, second_year, second_month,
    // second_day, zero fill
    input  logic [dbd_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // day_count, zero fill
    output logic [dbd_pkg::M_DATA_W-1:0]  m_tdata,
    // date_error
    output logic                          m_tuser
);
    import dbd_pkg::*;

    // Unpack the input beat
    localparam int F1M = YEAR_W;
    localparam int F1D = F1M + MONTH_W;
    localparam int F2Y = F1D + DAY_W;
    localparam int F2M = F2Y + YEAR_W;
    localparam int F2D = F2M + MONTH_W;

    logic [YEAR_W-1:0]  first_year, second_year;
    logic [MONTH_W-1:0] first_month, second_month;
    logic [DAY_W-1:0]   first_day, second_day;

    assign first_year   = s_tdata[0   +: YEAR_W];
    assign first_month  = s_tdata[F1M +: MONTH_W];
    assign first_day    = s_tdata[F1D +: DAY_W];
    assign second_year  = s_tdata[F2Y +: YEAR_W];
    assign second_month = s_tdata[F2M +: MONTH_W];
    assign second_day   = s_tdata[F2D +: DAY_W];

    // Pipeline control: a stage loads when it is empty or the next one moves
    logic      valid_a_reg, valid_b_reg, valid_c_reg, m_tvalid_reg;
    logic      rdy_a, rdy_b, rdy_c, rdy_d;
    stage_en_t en;

    assign rdy_d = !m_tvalid_reg || m_tready;
    assign rdy_c = !valid_c_reg  || rdy_d;
    assign rdy_b = !valid_b_reg  || rdy_c;
    assign rdy_a = !valid_a_reg  || rdy_b;

    assign en.stage_a = rdy_a;
    assign en.stage_b = rdy_b;
    assign en.stage_c = rdy_c;
    assign s_tready   = rdy_a;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg  <= 1'b0;
            valid_b_reg  <= 1'b0;
            valid_c_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (rdy_a) valid_a_reg  <= s_tvalid;
            if (rdy_b) valid_b_reg  <= valid_a_reg;
            if (rdy_c) valid_c_reg  <= valid_b_reg;
            if (rdy_d) m_tvalid_reg <= valid_c_reg;
        end
    end

    // Serial numbers of both dates
    logic [COUNT_W-1:0] serial_first, serial_second;
    logic               ok_first, ok_second;

    dbd_date_serial u_first (
        .aclk    (aclk),
        .en      (en),
        .year    (first_year),
        .month   (first_month),
        .day     (first_day),
        .serial  (serial_first),
        .date_ok (ok_first)
    );

    dbd_date_serial u_second (
        .aclk    (aclk),
        .en      (en),
        .year    (second_year),
        .month   (second_month),
        .day     (second_day),
        .serial  (serial_second),
        .date_ok (ok_second)
    );

    // Output stage: difference plus one, zeroed on error
    logic [COUNT_W-1:0] count_next;
    logic               error_next;
    logic [COUNT_W-1:0] count_reg;
    logic               error_reg;

    always_comb begin
        error_next = !(ok_first && ok_second);
        count_next = error_next ? '0
                                : serial_second - serial_first + COUNT_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (rdy_d) begin
            count_reg <= count_next;
            error_reg <= error_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_DATA_W-COUNT_W){1'b0}}, count_reg};
    assign m_tuser  = error_reg;

`ifndef SYNTHESIS
    // An erroneous beat carries a zero count
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[COUNT_W-1:0] == '0))
        else $error("error beat with non-zero day count");

    // A good count stays within the span of years 0 to 9999
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |->
            (($signed(m_tdata[COUNT_W-1:0]) <= $signed(COUNT_W'(3652425))) &&
             ($signed(m_tdata[COUNT_W-1:0]) >= $signed(-COUNT_W'(3652425)))))
        else $error("day count out of range");

    // With the output register empty, the whole pipeline can move
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output is empty");

    // A beat in the last date stage reaches the output register when it moves
    assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_c_reg && rdy_d) |=> m_tvalid)
        else $error("beat lost between date units and output");
`endif

endmodule

// ===== dv/dbd_day_count_checker.sv =====
// Checker for the day-count block: watches both stream channels, predicts the
// day count for every accepted date pair and compares it with the result beats.
// Depends on dbd_pkg for the field widths and stream packing.
`timescale 1ns / 1ps

module dbd_day_count_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [dbd_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [dbd_pkg::M_DATA_W-1:0] m_tdata,
    input  logic                         m_tuser,
    output int                           fail_count,
    output int                           pending_count
);
    import dbd_pkg::*;

    // Field offsets in s_tdata, lowest field first
    localparam int Y1_LO = 0;
    localparam int M1_LO = Y1_LO + YEAR_W;
    localparam int D1_LO = M1_LO + MONTH_W;
    localparam int Y2_LO = D1_LO + DAY_W;
    localparam int M2_LO = Y2_LO + YEAR_W;
    localparam int D2_LO = M2_LO + MONTH_W;

    localparam int MAX_REPORTS = 200;

    typedef struct packed {
        logic signed [COUNT_W-1:0] day_count;
        logic                      date_error;
    } day_result_t;

    day_result_t expected_counts[$];
    int          reports;

    function automatic bit leap_year(int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // Length of a month; zero for a month code outside the calendar
    function automatic int days_in_month(int y, int m);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return leap_year(y) ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    function automatic bit date_valid(int y, int m, int d);
        return (y <= int'(YEAR_MAX)) && (d >= 1) && (d <= days_in_month(y, m));
    endfunction

    // Days since the proleptic epoch, year 0 counted as a leap year
    function automatic int serial_day(int y, int m, int d);
        int s;
        s = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400 + d;
        for (int k = 1; k < m; k++)
            s += days_in_month(y, k);
        return s;
    endfunction

    function automatic day_result_t predict_day_count(logic [S_DATA_W-1:0] pair);
        int          y1, m1, d1, y2, m2, d2;
        int          span;
        day_result_t r;
        y1 = int'(pair[Y1_LO +: YEAR_W]);
        m1 = int'(pair[M1_LO +: MONTH_W]);
        d1 = int'(pair[D1_LO +: DAY_W]);
        y2 = int'(pair[Y2_LO +: YEAR_W]);
        m2 = int'(pair[M2_LO +: MONTH_W]);
        d2 = int'(pair[D2_LO +: DAY_W]);
        if (!date_valid(y1, m1, d1) || !date_valid(y2, m2, d2)) begin
            r.day_count  = '0;
            r.date_error = 1'b1;
        end else begin
            span         = serial_day(y2, m2, d2) - serial_day(y1, m1, d1) + 1;
            r.day_count  = span[COUNT_W-1:0];
            r.date_error = 1'b0;
        end
        return r;
    endfunction

    // Retire the result beat first, then queue the prediction for a new pair
    always @(posedge aclk) begin
        day_result_t exp_res;
        int          errs;
        errs = 0;
        if (!aresetn) begin
            expected_counts.delete();
            fail_count    <= 0;
            pending_count <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_counts.size() == 0) begin
                    errs++;
                    if (reports < MAX_REPORTS)
                        $display("%t: result beat with none expected, actual count %0d error %0b",
                                 $time, $signed(m_tdata[COUNT_W-1:0]), m_tuser);
                    reports++;
                end else begin
                    exp_res = expected_counts.pop_front();
                    if (m_tdata !== M_DATA_W'($unsigned(exp_res.day_count))) begin
                        errs++;
                        if (reports < MAX_REPORTS)
                            $display("%t: day_count mismatch, expected %0d, actual %0d (tdata %h)",
                                     $time, exp_res.day_count,
                                     $signed(m_tdata[COUNT_W-1:0]), m_tdata);
                        reports++;
                    end
                    if (m_tuser !== exp_res.date_error) begin
                        errs++;
                        if (reports < MAX_REPORTS)
                            $display("%t: date_error mismatch, expected %0b, actual %0b",
                                     $time, exp_res.date_error, m_tuser);
                        reports++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_counts.push_back(predict_day_count(s_tdata));
            pending_count <= expected_counts.size();
            fail_count    <= fail_count + errs;
        end
    end

endmodule

// ===== dv/days_between_dates_tb.sv =====
// Testbench top for days_between_dates: drives date pairs with random gaps and
// back-pressure, and gives the verdict from the count of dbd_day_count_checker.
// Depends on dbd_pkg, days_between_dates and dbd_day_count_checker.
`timescale 1ns / 1ps

module days_between_dates_tb;
    import dbd_pkg::*;

    localparam int RANDOM_PER_PHASE = 643;
    localparam int STALL_LEN        = 200;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int TAIL_CYCLES      = 12;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tuser;

    int fail_count;
    int pending_count;
    int in_beats    = 0;
    int quiet_count = 0;
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;

    days_between_dates dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    dbd_day_count_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Count input beats and quiet cycles; end the run if the channels hang
    always @(posedge aclk) begin
        if (s_tvalid && s_tready)
            in_beats <= in_beats + 1;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_count <= 0;
        else
            quiet_count <= quiet_count + 1;
        if (quiet_count >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result side: random back-pressure, plus two long holds to fill the pipeline
    initial begin
        int stalls_done;
        stalls_done = 0;
        @(posedge aclk);
        forever begin
            if ((stalls_done == 0 && in_beats >= 100) ||
                (stalls_done == 1 && in_beats >= 1500)) begin
                repeat (STALL_LEN) begin
                    m_tready <= 1'b0;
                    @(posedge aclk);
                end
                stalls_done++;
            end else begin
                m_tready <= ($urandom_range(99) >= sink_idle_pct);
                @(posedge aclk);
            end
        end
    end

    // Offer one beat after a random gap and hold it until accepted
    task automatic send_beat(input logic [S_DATA_W-1:0] data);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        do
            @(posedge aclk);
        while (!s_tready);
    endtask

    task automatic send_dates(input int y1, input int m1, input int d1,
                              input int y2, input int m2, input int d2);
        send_beat(S_DATA_W'({DAY_W'(d2), MONTH_W'(m2), YEAR_W'(y2),
                             DAY_W'(d1), MONTH_W'(m1), YEAR_W'(y1)}));
    endtask

    function automatic int month_days(int y, int m);
        case (m)
            2:           return (((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0)) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:     return 31;
        endcase
    endfunction

    // Mostly well-formed pairs, some close together or on century years, some noise
    task automatic send_random_pair();
        int kind, y1, m1, d1, y2, m2, d2;
        kind = $urandom_range(99);
        y1 = $urandom_range(9999);
        m1 = $urandom_range(1, 12);
        d1 = $urandom_range(1, month_days(y1, m1));
        y2 = $urandom_range(9999);
        m2 = $urandom_range(1, 12);
        d2 = $urandom_range(1, month_days(y2, m2));
        if (kind < 65) begin
            send_dates(y1, m1, d1, y2, m2, d2);
        end else if (kind < 75) begin
            // same year, often same month
            m2 = ($urandom_range(1)) ? m1 : m2;
            d2 = $urandom_range(1, month_days(y1, m2));
            send_dates(y1, m1, d1, y1, m2, d2);
        end else if (kind < 85) begin
            // century years and their neighbours, around February
            y1 = $urandom_range(99) * 100 + $urandom_range(2);
            y1 = (y1 > 9999) ? 9999 : y1;
            m1 = $urandom_range(2, 3);
            d1 = $urandom_range(month_days(y1, m1) - 1, month_days(y1, m1) + 1);
            send_dates(y1, m1, d1, y2, m2, d2);
        end else begin
            send_dates($urandom_range(16383), $urandom_range(15), $urandom_range(31),
                       $urandom_range(16383), $urandom_range(15), $urandom_range(31));
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        src_idle_pct  = 28;
        sink_idle_pct = 60;

        // Directed pairs: extremes, leap rules and invalid fields
        send_dates(2024, 3, 15, 2024, 3, 15);
        send_dates(0, 1, 1, 9999, 12, 31);
        send_dates(9999, 12, 31, 0, 1, 1);
        send_dates(0, 2, 29, 0, 3, 1);
        send_dates(1900, 2, 29, 1900, 3, 1);
        send_dates(2000, 2, 29, 2100, 2, 28);
        send_dates(2000, 1, 1, 2100, 2, 29);
        send_dates(2023, 12, 31, 2024, 1, 1);
        send_dates(2024, 1, 1, 2023, 12, 31);
        send_dates(2020, 0, 10, 2021, 5, 5);
        send_dates(2020, 6, 10, 2021, 13, 5);
        send_dates(2020, 15, 10, 2021, 5, 5);
        send_dates(2020, 6, 0, 2021, 5, 5);
        send_dates(2023, 4, 31, 2023, 5, 1);
        send_dates(2023, 1, 31, 2023, 12, 31);
        send_dates(10000, 1, 1, 2000, 1, 1);
        send_dates(16383, 15, 31, 16383, 15, 31);
        send_dates(1996, 2, 29, 2004, 2, 29);
        send_dates(1, 1, 1, 1, 1, 1);
        send_dates(400, 2, 29, 399, 12, 31);
        send_dates(9999, 12, 31, 10000, 1, 1);

        // Random pairs under three idling patterns
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct  = 28;
                    sink_idle_pct = 60;
                end
                1: begin
                    src_idle_pct  = 60;
                    sink_idle_pct = 28;
                end
                default: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            repeat (RANDOM_PER_PHASE) send_random_pair();
        end

        // Drain and give the verdict
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
src/dbd_pkg.sv
src/dbd_date_serial.sv
src/days_between_dates.sv
dv/dbd_day_count_checker.sv
dv/days_between_dates_tb.sv
